// File: rtl/core/bdda_pkg.sv
// Shared types, constants and calendar functions for the business-day date adder.
package bdda_pkg;

    localparam int unsigned DAY_W     = 5;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned COUNT_W   = 15;
    localparam int unsigned WDAY_W    = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned MASK_W    = 7;

    localparam logic [YEAR_W-1:0]  MAX_YEAR      = 14'd9999;
    localparam logic [MASK_W-1:0]  MASK_RESET    = 7'd96;
    localparam logic [MASK_W-1:0]  MASK_ALL      = 7'h7F;
    localparam logic [WDAY_W-1:0]  WDAY_MAX_DATE = 3'd5;   // weekday of 31 Dec 9999
    localparam logic [WDAY_W-1:0]  WDAY_SAT      = 3'd6;

    // Reciprocal multipliers: y*5243 >> 19 is y/100 and s*37450 >> 18 is s/7
    // for every value these fields can carry.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [15:0] RECIP_7   = 16'd37450;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic load;      // capture an accepted input transaction
        logic div;       // year / 100
        logic prep;      // validate, leap, weekday sum
        logic mod_a;     // sum / 7
        logic mod_b;     // sum % 7
        logic step;      // walk one calendar day
        logic out_load;  // move result into output register
    } bdda_cmd_t;

    typedef struct packed {
        logic finished;  // walk complete or never needed
        logic out_free;  // output register can take a result
    } bdda_stat_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 with mm the March-based month number.
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] t;
        case (m)
            4'd1:    t = 5'd28;
            4'd2:    t = 5'd31;
            4'd3:    t = 5'd2;
            4'd4:    t = 5'd5;
            4'd5:    t = 5'd7;
            4'd6:    t = 5'd10;
            4'd7:    t = 5'd12;
            4'd8:    t = 5'd15;
            4'd9:    t = 5'd18;
            4'd10:   t = 5'd20;
            4'd11:   t = 5'd23;
            4'd12:   t = 5'd25;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/bdda_ctrl.sv
// Sequencer for the business-day date adder: setup steps, day walk, result hand-off.
module bdda_ctrl
    import bdda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bdda_stat_t stat,
    output bdda_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MOD_A,
        ST_MOD_B,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MOD_A;
            end
            ST_MOD_A:
            begin
                cmd.mod_a  = 1'b1;
                state_next = ST_MOD_B;
            end
            ST_MOD_B:
            begin
                cmd.mod_b  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.finished)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/bdda_dp.sv
// Datapath for the business-day date adder: date registers, weekday math, output stage.
module bdda_dp
    import bdda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  bdda_cmd_t           cmd,
    output bdda_stat_t          stat,
    input  logic                cfg_wr_en,
    input  logic [MASK_W-1:0]   cfg_wr_data,
    input  logic [DAY_W-1:0]    start_day,
    input  logic [MONTH_W-1:0]  start_month,
    input  logic [YEAR_W-1:0]   start_year,
    input  logic [COUNT_W-1:0]  business_days,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [DAY_W-1:0]    end_day,
    output logic [MONTH_W-1:0]  end_month,
    output logic [YEAR_W-1:0]   end_year,
    output logic [WDAY_W-1:0]   end_weekday,
    output logic [STATUS_W-1:0] status
);

    logic [MASK_W-1:0]   mask_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [WDAY_W-1:0]   wday_reg;
    logic [COUNT_W-1:0]  left_reg;
    logic [STATUS_W-1:0] stat_reg;
    logic                stop_reg;
    logic [7:0]          q100_reg;     // year / 100
    logic [6:0]          cnt100_reg;   // year % 100
    logic [1:0]          cnt4c_reg;    // (year / 100) % 4
    logic [14:0]         sum_reg;
    logic [12:0]         q7_reg;
    logic                out_valid_reg;
    logic [DAY_W-1:0]    out_day_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [YEAR_W-1:0]   out_year_reg;
    logic [WDAY_W-1:0]   out_wday_reg;
    logic [STATUS_W-1:0] out_stat_reg;

    // Setup arithmetic
    logic [26:0]        prod100;
    logic [14:0]        rem100_full;
    logic [6:0]         mod100;
    logic               leap_in;
    logic               date_ok;
    logic               early_feb;
    logic [YEAR_W-1:0]  yy;
    logic [7:0]         yy_q100;
    logic [14:0]        wsum;
    logic [30:0]        prod7;
    logic [14:0]        rem7_full;
    logic [WDAY_W-1:0]  wday_calc;

    // Walk arithmetic
    logic               leap_walk;
    logic               at_max;
    logic               month_end;
    logic [7:0]         mask8;
    logic               biz_day;

    assign prod100     = 27'(year_reg) * 27'(RECIP_100);
    assign rem100_full = {1'b0, year_reg} - (15'(q100_reg) * 15'd100);
    assign mod100      = rem100_full[6:0];
    assign leap_in     = (year_reg[1:0] == 2'd0) && ((mod100 != 7'd0) || (q100_reg[1:0] == 2'd0));
    assign date_ok     = (year_reg != '0) && (year_reg <= MAX_YEAR) &&
                         (month_reg >= 4'd1) && (month_reg <= 4'd12) &&
                         (day_reg != '0) && (day_reg <= days_in_month(month_reg, leap_in));

    // January and February count as months of the previous year.
    assign early_feb = (month_reg <= 4'd2);
    assign yy        = year_reg - YEAR_W'(early_feb);
    assign yy_q100   = q100_reg - 8'((early_feb && (mod100 == 7'd0)) ? 1 : 0);
    assign wsum      = 15'(day_reg) + 15'(yy) + 15'(yy >> 2) - 15'(yy_q100)
                     + 15'(yy_q100 >> 2) + 15'(month_term(month_reg));

    assign prod7     = 31'(sum_reg) * 31'(RECIP_7);
    assign rem7_full = sum_reg - (15'(q7_reg) * 15'd7);
    assign wday_calc = rem7_full[WDAY_W-1:0];

    assign leap_walk = (year_reg[1:0] == 2'd0) && ((cnt100_reg != 7'd0) || (cnt4c_reg == 2'd0));
    assign at_max    = (day_reg == 5'd31) && (month_reg == 4'd12) && (year_reg == MAX_YEAR);
    assign month_end = (day_reg == days_in_month(month_reg, leap_walk));
    assign mask8     = {1'b0, mask_reg};
    assign biz_day   = !mask8[wday_reg];

    assign stat.finished = stop_reg || (left_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= MASK_RESET;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                stop_reg <= 1'b0;
            end
            else if (cmd.prep)
            begin
                stop_reg <= !date_ok || ((left_reg != '0) && (mask_reg == MASK_ALL));
            end
            else if (cmd.step && at_max)
            begin
                stop_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            day_reg   <= start_day;
            month_reg <= start_month;
            year_reg  <= start_year;
            left_reg  <= business_days;
        end
        if (cmd.div)
        begin
            q100_reg <= prod100[26:19];
        end
        if (cmd.prep)
        begin
            sum_reg    <= wsum;
            cnt100_reg <= mod100;
            cnt4c_reg  <= q100_reg[1:0];
            if (!date_ok)
            begin
                stat_reg <= STAT_INVALID;
            end
            else if ((left_reg != '0) && (mask_reg == MASK_ALL))
            begin
                // No business day exists: jump straight to the last date.
                stat_reg  <= STAT_OVERFLOW;
                day_reg   <= 5'd31;
                month_reg <= 4'd12;
                year_reg  <= MAX_YEAR;
            end
            else
            begin
                stat_reg <= STAT_OK;
            end
        end
        if (cmd.mod_a)
        begin
            q7_reg <= prod7[30:18];
        end
        if (cmd.mod_b)
        begin
            case (stat_reg)
                STAT_INVALID:  wday_reg <= '0;
                STAT_OVERFLOW: wday_reg <= WDAY_MAX_DATE;
                default:       wday_reg <= wday_calc;
            endcase
        end
        if (cmd.step)
        begin
            if (biz_day)
            begin
                left_reg <= left_reg - 1'b1;
            end
            if (at_max)
            begin
                stat_reg <= STAT_OVERFLOW;
            end
            else
            begin
                wday_reg <= (wday_reg == WDAY_SAT) ? '0 : wday_reg + 1'b1;
                if (month_end)
                begin
                    day_reg <= 5'd1;
                    if (month_reg == 4'd12)
                    begin
                        month_reg <= 4'd1;
                        year_reg  <= year_reg + 1'b1;
                        if (cnt100_reg == 7'd99)
                        begin
                            cnt100_reg <= '0;
                            cnt4c_reg  <= cnt4c_reg + 1'b1;
                        end
                        else
                        begin
                            cnt100_reg <= cnt100_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        month_reg <= month_reg + 1'b1;
                    end
                end
                else
                begin
                    day_reg <= day_reg + 1'b1;
                end
            end
        end
        if (cmd.out_load)
        begin
            out_day_reg   <= day_reg;
            out_month_reg <= month_reg;
            out_year_reg  <= year_reg;
            out_wday_reg  <= wday_reg;
            out_stat_reg  <= stat_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign end_day     = out_day_reg;
    assign end_month   = out_month_reg;
    assign end_year    = out_year_reg;
    assign end_weekday = out_wday_reg;
    assign status      = out_stat_reg;

    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_stat_reg == STAT_OVERFLOW) |->
            (out_day_reg == 5'd31) && (out_month_reg == 4'd12) && (out_year_reg == MAX_YEAR))
        else $error("overflow result is not 31 Dec 9999");

    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_stat_reg == STAT_OK) |->
            (out_year_reg != '0) && (out_year_reg <= MAX_YEAR) && (out_day_reg != '0))
        else $error("ok result carries an impossible date");

    a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !stop_reg && (left_reg != '0))
        else $error("walk step issued after the walk finished");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (left_reg == $past(left_reg)) || (left_reg == $past(left_reg) - 1'b1))
        else $error("business day count moved by more than one");

endmodule

// File: rtl/core/business_day_date_adder_unit.sv
// Top level of the business-day date adder: stream ports around sequencer and datapath.
//
// Each input transaction carries a Gregorian start date and a count of business days.
// The unit walks forward one calendar day per clock; a day whose weekday bit is clear
// in weekend_mask lowers the count before the advance, and the walk ends when the count
// reaches zero, so a count of zero returns the start date. The result is the reached
// date, its weekday (0 Sunday) and a status: ok, invalid start date (the input date is
// echoed with weekday 0), or year overflow (the walk stopped at 31 Dec 9999). An all-
// weekend mask with a nonzero count answers the overflow date without walking. A
// transaction moves from accept through setup steps that validate the date and derive
// its weekday through reciprocal multiplies, then through the date stepper, which walks
// one calendar day at a time, a finish check and the load of the output register, which
// waits until that register is free. The stepper handles one transaction at a time; the
// output register holds a finished result while the next transaction is accepted.
// weekend_mask (reset Friday and Saturday) is written through cfg_wr_en / cfg_wr_data
// and must only change while the unit is idle.
module business_day_date_adder_unit
    import bdda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,     // weekend_mask
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], business_days[37:23]
    input  logic [39:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // end_day[4:0], end_month[8:5], end_year[22:9], end_weekday[25:23]
    output logic [31:0]       m_axis_tdata,
    // status[1:0]
    output logic [1:0]        m_axis_tuser
);

    bdda_cmd_t           cmd;
    bdda_stat_t          stat;
    logic [DAY_W-1:0]    end_day;
    logic [MONTH_W-1:0]  end_month;
    logic [YEAR_W-1:0]   end_year;
    logic [WDAY_W-1:0]   end_weekday;
    logic [STATUS_W-1:0] status;

    bdda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Unpack the input transaction straight into the datapath's capture registers.
    bdda_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .start_day     (s_axis_tdata[4:0]),
        .start_month   (s_axis_tdata[8:5]),
        .start_year    (s_axis_tdata[22:9]),
        .business_days (s_axis_tdata[37:23]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .end_day       (end_day),
        .end_month     (end_month),
        .end_year      (end_year),
        .end_weekday   (end_weekday),
        .status        (status)
    );

    // Pack the result transaction; pad bits are zero.
    assign m_axis_tdata = {6'd0, end_weekday, end_year, end_month, end_day};
    assign m_axis_tuser = status;

endmodule

// File: test/business_day_date_adder_checker.sv
// Scoreboard for the business-day date adder: watches both streams, predicts and compares.
`timescale 1ns / 100ps

module business_day_date_adder_checker
    import bdda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [31:0]       m_axis_tdata,
    input  logic [1:0]        m_axis_tuser,
    output int                pending_dates,
    output int                mismatch_count
);

    localparam int unsigned MONTH_LO = DAY_W;
    localparam int unsigned YEAR_LO  = MONTH_LO + MONTH_W;
    localparam int unsigned COUNT_LO = YEAR_LO + YEAR_W;
    localparam int unsigned WDAY_LO  = YEAR_LO + YEAR_W;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [WDAY_W-1:0]   wday;
        logic [STATUS_W-1:0] status;
    } date_result_t;

    date_result_t      due_dates[$];
    logic [MASK_W-1:0] rest_days;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Zeller congruence, shifted so that 0 is Sunday.
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned yy;
        int unsigned mm;
        int unsigned h;
        yy = y;
        mm = m;
        if (mm < 3)
        begin
            mm += 12;
            yy -= 1;
        end
        h = (d + (13 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
        return (h + 6) % 7;
    endfunction

    function automatic date_result_t reach_business_date(input logic [DAY_W-1:0] d_in,
                                                         input logic [MONTH_W-1:0] m_in,
                                                         input logic [YEAR_W-1:0] y_in,
                                                         input logic [COUNT_W-1:0] n_in,
                                                         input logic [MASK_W-1:0] mask);
        date_result_t r;
        int unsigned  d;
        int unsigned  m;
        int unsigned  y;
        int unsigned  n;
        int unsigned  wd;
        d = d_in;
        m = m_in;
        y = y_in;
        n = n_in;
        r.status = STAT_OK;
        if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1 || d > month_length(m, y))
        begin
            r.day    = d_in;
            r.month  = m_in;
            r.year   = y_in;
            r.wday   = '0;
            r.status = STAT_INVALID;
            return r;
        end
        wd = day_of_week(y, m, d);
        if (n != 0 && mask == MASK_ALL)
        begin
            // no business day at all: jump straight to the last representable date
            d  = 31;
            m  = 12;
            y  = MAX_YEAR;
            wd = day_of_week(y, m, d);
            r.status = STAT_OVERFLOW;
        end
        else
        begin
            while (n != 0)
            begin
                if (!mask[wd])
                    n--;
                if (d == month_length(m, y))
                begin
                    if (m == 12)
                    begin
                        if (y == MAX_YEAR)
                        begin
                            r.status = STAT_OVERFLOW;
                            break;
                        end
                        y++;
                        m = 1;
                    end
                    else
                        m++;
                    d = 1;
                end
                else
                    d++;
                wd = (wd + 1) % 7;
            end
        end
        r.day   = d[DAY_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.year  = y[YEAR_W-1:0];
        r.wday  = wd[WDAY_W-1:0];
        return r;
    endfunction

    function automatic int check_field(input string field, input int unsigned want,
                                       input int unsigned got);
        if (want == got)
            return 0;
        $error("%s: expected %0d, actual %0d", field, want, got);
        return 1;
    endfunction

    always @(posedge clk)
    begin
        date_result_t want;
        int           errs;
        errs = 0;
        if (!rst_n)
        begin
            rest_days = MASK_RESET;
            due_dates.delete();
        end
        else
        begin
            if (cfg_wr_en)
                rest_days = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_dates.size() == 0)
                begin
                    $error("result transaction with no request pending: data %h status %0d",
                           m_axis_tdata, m_axis_tuser);
                    errs++;
                end
                else
                begin
                    want = due_dates.pop_front();
                    errs += check_field("end_day", want.day, m_axis_tdata[DAY_W-1:0]);
                    errs += check_field("end_month", want.month,
                                        m_axis_tdata[MONTH_LO +: MONTH_W]);
                    errs += check_field("end_year", want.year, m_axis_tdata[YEAR_LO +: YEAR_W]);
                    errs += check_field("end_weekday", want.wday,
                                        m_axis_tdata[WDAY_LO +: WDAY_W]);
                    errs += check_field("status", want.status, m_axis_tuser);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_dates.push_back(reach_business_date(s_axis_tdata[DAY_W-1:0],
                                                        s_axis_tdata[MONTH_LO +: MONTH_W],
                                                        s_axis_tdata[YEAR_LO +: YEAR_W],
                                                        s_axis_tdata[COUNT_LO +: COUNT_W],
                                                        rest_days));
        end
        pending_dates  <= due_dates.size();
        mismatch_count <= mismatch_count + errs;
    end

endmodule

// File: test/tb_business_day_date_adder_unit.sv
// Testbench top for the business-day date adder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_business_day_date_adder_unit;
    import bdda_pkg::*;

    // Slowest plausible run: ~1500 random requests (walk, sender gap, receiver stall, setup)
    // plus a handful of full-count walks; the timeout allows several times that.
    localparam int unsigned TIMEOUT_CYCLES = 8_000_000;
    localparam int unsigned PHASE_ITEMS    = 200;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [MASK_W-1:0] cfg_wr_data   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    int                pending_dates;
    int                mismatch_count;

    // Weekend mask currently loaded in the unit; the random generator sizes its counts
    // from the number of business days per week that it leaves.
    logic [MASK_W-1:0] cur_mask        = MASK_RESET;
    // Full-range counts make very long walks; keep them few.
    int                long_walks_left = 6;
    // Stretches with no sender gaps (tx_calm) or no receiver stalls (rx_calm).
    bit                tx_calm         = 1'b0;
    bit                rx_calm         = 1'b0;
    int                rx_hold         = 0;

    business_day_date_adder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    business_day_date_adder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .pending_dates  (pending_dates),
        .mismatch_count (mismatch_count)
    );

    always #6 clk = ~clk;

    // Result side: after each accepted transaction, drop tready unless the drawn stall is
    // zero, then hold it high until the next result is taken. Every so often toggle into or
    // out of a stall-free stretch.
    always @(posedge clk)
    begin
        int stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm <= !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            rx_hold       <= stall;
            m_axis_tready <= (stall == 0);
        end
        else if (rx_hold > 1)
            rx_hold <= rx_hold - 1;
        else
        begin
            rx_hold       <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one request and return at the edge that accepts it. Valid stays high into
    // the next call when that call draws no gap, so back-to-back transactions occur.
    task automatic send_date(input logic [DAY_W-1:0] day, input logic [MONTH_W-1:0] month,
                             input logic [YEAR_W-1:0] year, input logic [COUNT_W-1:0] count);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, count, year, month, day};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering and hold until every accepted request has produced its result.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates != 0);
    endtask

    // Change the weekend mask only with the unit fully idle.
    task automatic set_weekend(input logic [MASK_W-1:0] mask);
        wait_all_results();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mask;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_mask     = mask;
    endtask

    // Mostly valid dates, with month ends, the last year and the first years favored;
    // a slice of raw bit patterns covers invalid dates. Counts scale with the number
    // of business days per week so that walks stay short, except a rare full-range one.
    task automatic send_random_date();
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
        int unsigned        pick;
        int unsigned        workdays;
        workdays = MASK_W - $countones(cur_mask);
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            day   = DAY_W'($urandom);
            month = MONTH_W'($urandom);
            year  = YEAR_W'($urandom);
        end
        else
        begin
            if (pick < 14)
            begin
                year  = MAX_YEAR;
                month = MONTH_W'($urandom_range(10, 12));
            end
            else if (pick < 20)
            begin
                year  = YEAR_W'($urandom_range(9990, 9999));
                month = MONTH_W'($urandom_range(1, 12));
            end
            else if (pick < 25)
            begin
                year  = YEAR_W'($urandom_range(1, 4));
                month = MONTH_W'($urandom_range(1, 12));
            end
            else
            begin
                year  = YEAR_W'($urandom_range(1, 9999));
                month = MONTH_W'($urandom_range(1, 12));
            end
            day = DAY_W'(($urandom_range(0, 4) == 0) ? $urandom_range(29, 31)
                                                     : $urandom_range(1, 28));
        end
        pick = $urandom_range(0, 999);
        if (workdays == 0)
            count = (pick < 100) ? '0 : COUNT_W'($urandom);
        else if (pick < 3 && workdays >= 5 && long_walks_left > 0)
        begin
            count = COUNT_W'($urandom);
            long_walks_left--;
        end
        else if (pick < 60)
            count = '0;
        else if (pick < 160)
            count = COUNT_W'($urandom_range(0, 100 * workdays));
        else
            count = COUNT_W'($urandom_range(0, 10 * workdays));
        send_date(day, month, year, count);
    endtask

    initial
    begin
        logic [MASK_W-1:0] phase_masks [8];
        phase_masks[0] = 7'h00;
        phase_masks[1] = MASK_W'($urandom_range(0, 127));
        phase_masks[2] = 7'h7E;
        phase_masks[3] = 7'h01;
        phase_masks[4] = 7'h41;
        phase_masks[5] = MASK_W'($urandom_range(0, 127));
        phase_masks[6] = MASK_ALL;
        phase_masks[7] = MASK_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mask (Friday and Saturday off): field extremes, calendar corners,
        // invalid dates and the overflow at the end of year 9999.
        send_date(5'd1, 4'd1, 14'd1, 15'd0);
        send_date(5'd31, 4'd12, MAX_YEAR, 15'd0);
        send_date(5'd31, 4'd12, MAX_YEAR, 15'd1);          // Friday: overflow at once
        send_date(5'd25, 4'd12, MAX_YEAR, 15'h7FFF);
        send_date(5'd31, 4'd12, 14'd9998, 15'd300);        // crosses into overflow
        send_date(5'd1, 4'd1, 14'd2024, 15'd10);
        send_date(5'd29, 4'd2, 14'd2024, 15'd1);           // leap day
        send_date(5'd29, 4'd2, 14'd2023, 15'd4);           // not a leap year
        send_date(5'd29, 4'd2, 14'd1900, 15'd4);           // century, not leap
        send_date(5'd29, 4'd2, 14'd2000, 15'd3);           // 400-year leap
        send_date(5'd28, 4'd2, 14'd2100, 15'd2);
        send_date(5'd0, 4'd6, 14'd2010, 15'd5);            // day zero
        send_date(5'd15, 4'd0, 14'd2010, 15'd5);           // month zero
        send_date(5'd31, 4'd15, 14'd2010, 15'd5);          // month out of range
        send_date(5'd31, 4'd4, 14'd2021, 15'd5);           // day past month end
        send_date(5'd10, 4'd10, 14'd0, 15'd5);             // year zero
        send_date(5'd31, 4'd12, 14'h3FFF, 15'h7FFF);       // year above 9999
        send_date(5'd30, 4'd12, 14'd2023, 15'd5);          // year wrap
        send_date(5'd31, 4'd1, 14'd1, 15'h7FFF);           // longest count

        // Every day a weekend: a zero count echoes the start, any other overflows.
        set_weekend(MASK_ALL);
        send_date(5'd15, 4'd6, 14'd2020, 15'd0);
        send_date(5'd15, 4'd6, 14'd2020, 15'd7);
        send_date(5'd31, 4'd12, MAX_YEAR, 15'd0);
        send_date(5'd30, 4'd2, 14'd2020, 15'd9);           // invalid wins over overflow

        // No weekend at all: every calendar day counts.
        set_weekend(7'h00);
        send_date(5'd28, 4'd2, 14'd2100, 15'd1);
        send_date(5'd31, 4'd12, MAX_YEAR, 15'd1);

        // Random phases, one weekend mask each, ending back at the reset mask.
        foreach (phase_masks[i])
        begin
            set_weekend(phase_masks[i]);
            repeat ((phase_masks[i] == MASK_ALL) ? 60 : PHASE_ITEMS)
            begin
                // Now and then hold off until the unit has drained completely.
                if ($urandom_range(0, 59) == 0)
                    wait_all_results();
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                send_random_date();
            end
        end

        wait_all_results();
        // Give a stray extra result time to show up before the verdict.
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

endmodule
